// File: rtl/modexp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared types and constants for the controller and the datapath.
// ----------------------------------------------------------------------------
package modexp_pkg;

    // Modulus after reset (2^64 - 59); the top level keeps its low word bits.
    localparam logic [63:0] MOD_RESET = 64'd18446744073709551557;

    typedef enum logic [2:0] {
        DP_NOP,
        DP_LOAD,
        DP_DIV_STEP,
        DP_SQ_START,
        DP_MB_START,
        DP_MUL_STEP,
        DP_MUL_LAST
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   exp_shift;
    } t_dp_cmd;

    typedef struct packed {
        logic exp_msb;
    } t_dp_stat;

endpackage

// File: rtl/modexp_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation datapath
// Base reduction by restoring division, add-and-double modular multiply and
// the exponent shift register, all driven one step a cycle by commands.
// ----------------------------------------------------------------------------
module modexp_dp #(
    parameter int WORD_BITS = 64
) (
    input  logic                   i_clk,
    input  modexp_pkg::t_dp_cmd    i_cmd,
    input  logic [WORD_BITS-1:0]   i_modulus,
    input  logic [WORD_BITS-1:0]   i_base,
    input  logic [WORD_BITS-1:0]   i_exponent,
    output modexp_pkg::t_dp_stat   o_stat,
    output logic [WORD_BITS-1:0]   o_result
);
    import modexp_pkg::*;

    logic [WORD_BITS-1:0] r_num;
    logic [WORD_BITS-1:0] r_rem;
    logic [WORD_BITS-1:0] r_exp;
    logic [WORD_BITS-1:0] r_r;
    logic [WORD_BITS-1:0] r_a;
    logic [WORD_BITS-1:0] r_mb;
    logic [WORD_BITS-1:0] r_acc;

    logic [WORD_BITS:0]   w_rem_sh;
    logic [WORD_BITS:0]   w_rem_sub;
    logic [WORD_BITS-1:0] n_rem;
    logic [WORD_BITS-1:0] w_gap;
    logic [WORD_BITS-1:0] n_acc;
    logic [WORD_BITS-1:0] n_a;

    always_comb begin
        w_rem_sh  = {r_rem, r_num[WORD_BITS-1]};
        w_rem_sub = w_rem_sh - {1'b0, i_modulus};
        if (w_rem_sh >= {1'b0, i_modulus}) begin
            n_rem = w_rem_sub[WORD_BITS-1:0];
        end else begin
            n_rem = w_rem_sh[WORD_BITS-1:0];
        end

        w_gap = i_modulus - r_a;
        if (!r_mb[0]) begin
            n_acc = r_acc;
        end else if (r_acc >= w_gap) begin
            n_acc = r_acc - w_gap;
        end else begin
            n_acc = r_acc + r_a;
        end
        if (r_a >= w_gap) begin
            n_a = r_a - w_gap;
        end else begin
            n_a = r_a + r_a;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            DP_LOAD: begin
                r_num <= i_base;
                r_rem <= '0;
                r_r   <= WORD_BITS'(1);
            end
            DP_DIV_STEP: begin
                r_num <= r_num << 1;
                r_rem <= n_rem;
            end
            DP_SQ_START: begin
                r_a   <= r_r;
                r_mb  <= r_r;
                r_acc <= '0;
            end
            DP_MB_START: begin
                r_a   <= r_r;
                r_mb  <= r_rem;
                r_acc <= '0;
            end
            DP_MUL_STEP: begin
                r_a   <= n_a;
                r_mb  <= r_mb >> 1;
                r_acc <= n_acc;
            end
            DP_MUL_LAST: begin
                r_r   <= n_acc;
            end
            default: begin
            end
        endcase

        if (i_cmd.op == DP_LOAD) begin
            r_exp <= i_exponent;
        end else if (i_cmd.exp_shift) begin
            r_exp <= r_exp << 1;
        end
    end

    assign o_stat.exp_msb = r_exp[WORD_BITS-1];
    assign o_result       = (i_modulus < WORD_BITS'(2)) ? '0 : r_r;

endmodule

// File: rtl/modexp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation controller
// Sequences base reduction, then square and conditional multiply for every
// exponent bit from the top down, and hands the result to the output stage.
// ----------------------------------------------------------------------------
module modexp_ctrl #(
    parameter int WORD_BITS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_out_free,
    input  modexp_pkg::t_dp_stat  i_stat,
    output modexp_pkg::t_dp_cmd   o_cmd,
    output logic                  o_busy,
    output logic                  o_out_load
);
    import modexp_pkg::*;

    localparam int CW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam logic [CW-1:0] LAST = CW'(WORD_BITS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_SQ_START,
        S_SQ_RUN,
        S_MB_START,
        S_MB_RUN,
        S_FINISH
    } t_state;

    t_state        r_state;
    logic [CW-1:0] r_step;
    logic [CW-1:0] r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_bit   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_REDUCE;
                        r_step  <= '0;
                        r_bit   <= '0;
                    end
                end
                S_REDUCE: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == LAST) begin
                        r_state <= S_SQ_START;
                    end
                end
                S_SQ_START, S_MB_START: begin
                    r_step  <= '0;
                    r_state <= (r_state == S_SQ_START) ? S_SQ_RUN : S_MB_RUN;
                end
                S_SQ_RUN, S_MB_RUN: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == LAST) begin
                        if (r_state == S_SQ_RUN && i_stat.exp_msb) begin
                            r_state <= S_MB_START;
                        end else if (r_bit == LAST) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_bit   <= r_bit + 1'b1;
                            r_state <= S_SQ_START;
                        end
                    end
                end
                S_FINISH: begin
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd.op        = DP_NOP;
        o_cmd.exp_shift = 1'b0;
        unique case (r_state)
            S_IDLE:     o_cmd.op = i_start ? DP_LOAD : DP_NOP;
            S_REDUCE:   o_cmd.op = DP_DIV_STEP;
            S_SQ_START: o_cmd.op = DP_SQ_START;
            S_MB_START: o_cmd.op = DP_MB_START;
            S_SQ_RUN, S_MB_RUN: begin
                if (r_step == LAST) begin
                    o_cmd.op        = DP_MUL_LAST;
                    o_cmd.exp_shift = (r_state == S_MB_RUN) || !i_stat.exp_msb;
                end else begin
                    o_cmd.op = DP_MUL_STEP;
                end
            end
            default: o_cmd.op = DP_NOP;
        endcase
    end

    assign o_busy     = (r_state != S_IDLE);
    assign o_out_load = (r_state == S_FINISH) && i_out_free;

endmodule

// File: rtl/modular_exponentiation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation
// Computes power = base ^ exponent mod modulus with a configurable modulus.
//
// The input channel (i_valid, o_stall) carries a base and an exponent; the
// output channel (o_valid, i_stall) carries the power. A transaction happens
// on a rising edge where valid is high and stall is low. The modulus is
// written through i_modulus_we / i_modulus; the user must write it only
// while no work is in flight; the block itself does not enforce this. One
// transaction is worked on at a time. With W = WORD_BITS, W division steps
// reduce the base after the input transaction, then every exponent bit
// costs a square and, when set, a multiply in the shared add-and-double unit.
// The input is taken again in the cycle after the result moves into the
// output register, so a waiting result does not hold off the next input.
// If the receiver stalls with the output register full, the finished result
// waits in the datapath until the register frees up.
// Synchronous reset empties the pipeline and restores modulus 2^64 - 59.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
    parameter int WORD_BITS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_modulus_we,
    input  logic [WORD_BITS-1:0] i_modulus,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [WORD_BITS-1:0] i_base,
    input  logic [WORD_BITS-1:0] i_exponent,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [WORD_BITS-1:0] o_power
);
    import modexp_pkg::*;

    logic [WORD_BITS-1:0] r_modulus;
    logic                 r_out_valid;
    logic [WORD_BITS-1:0] r_power;

    t_dp_cmd              w_cmd;
    t_dp_stat             w_stat;
    logic [WORD_BITS-1:0] w_result;
    logic                 w_busy;
    logic                 w_start;
    logic                 w_out_free;
    logic                 w_out_load;

    assign w_start    = i_valid && !w_busy;
    assign w_out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MOD_RESET[WORD_BITS-1:0];
        end else if (i_modulus_we) begin
            r_modulus <= i_modulus;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_power <= w_result;
        end
    end

    modexp_ctrl #(
        .WORD_BITS (WORD_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_out_free (w_out_free),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_busy     (w_busy),
        .o_out_load (w_out_load)
    );

    modexp_dp #(
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_cmd      (w_cmd),
        .i_modulus  (r_modulus),
        .i_base     (i_base),
        .i_exponent (i_exponent),
        .o_stat     (w_stat),
        .o_result   (w_result)
    );

    assign o_stall = w_busy;
    assign o_valid = r_out_valid;
    assign o_power = r_power;

    // An accepted transaction keeps the block busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("block not busy after input transaction");

    // Reset leaves the block idle with an empty output register.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("block not idle after reset");

    // A result never overwrites one that the receiver is stalling.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> !(o_valid && i_stall))
        else $error("output register overwritten while stalled");

endmodule
